>>> design/rrs_pkg.sv
// ----------------------------------------------------------------------------
// rrs_pkg: shared types and constants of the round-robin scheduler
// Payload structs, command and status codes, sequencer states and the
// command / status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rrs_pkg;

  localparam int MAX_TASKS_DEF = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_SLICE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TPS   = 2'd1;

  localparam logic [7:0] SLICE_RST = 8'd10;
  localparam logic [9:0] TPS_RST   = 10'd100;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_CREATE = 3'd1,
    CMD_SLEEP  = 3'd2,
    CMD_TERM   = 3'd3,
    CMD_QUERY  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_NOSLOT = 2'd1,
    STS_NORUN  = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        from_user;
    logic [15:0] sleep_seconds;
  } rrs_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        running_valid;
    logic [3:0]  running_task;
    logic [3:0]  created_task;
    logic        switched;
    logic [31:0] system_ticks;
    logic [31:0] user_ticks;
    logic [31:0] total_ticks;
  } rrs_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } rrs_cfg_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_TCHG, ST_SLP_INIT, ST_SLP_A, ST_SLP_B,
    ST_TEXP, ST_CSCAN, ST_SMUL, ST_QRD, ST_FIN, ST_OUT
  } state_e;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_DISPATCH, OP_TCHG, OP_SLP_INIT, OP_SLP_A, OP_SLP_B,
    OP_TEXP, OP_CSCAN, OP_SMUL, OP_QRD, OP_FIN, OP_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       rcount_zero;
    logic       scount_zero;
    logic       used_cur;
    logic       scan_last;
    logic       slp_last;
    logic       out_free;
  } dp_stat_t;

endpackage

>>> design/rrs_chan_if.sv
// ----------------------------------------------------------------------------
// rrs_chan_if: valid/ready channel
// Generic channel carrying one payload beat per valid and ready handshake.
// ----------------------------------------------------------------------------
interface rrs_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/rrs_ctrl.sv
// ----------------------------------------------------------------------------
// rrs_ctrl: scheduler sequencer
// Steps each command through its datapath operations, one per cycle.
// ----------------------------------------------------------------------------
module rrs_ctrl
  import rrs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output ctl_cmd_t cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (stat_i.cmd)
          CMD_TICK:   state_d = stat_i.rcount_zero ? ST_SLP_INIT : ST_TCHG;
          CMD_CREATE: state_d = ST_CSCAN;
          CMD_QUERY:  state_d = stat_i.rcount_zero ? ST_FIN : ST_QRD;
          CMD_SLEEP:  state_d = stat_i.rcount_zero ? ST_FIN : ST_SMUL;
          default:    state_d = ST_FIN;
        endcase
      end
      ST_TCHG:     state_d = ST_SLP_INIT;
      ST_SLP_INIT: state_d = stat_i.scount_zero ? ST_TEXP : ST_SLP_A;
      ST_SLP_A:    state_d = ST_SLP_B;
      ST_SLP_B:    state_d = stat_i.slp_last ? ST_TEXP : ST_SLP_A;
      ST_TEXP:     state_d = ST_FIN;
      ST_CSCAN: begin
        if (!stat_i.used_cur || stat_i.scan_last) state_d = ST_FIN;
      end
      ST_SMUL:     state_d = ST_FIN;
      ST_QRD:      state_d = ST_FIN;
      ST_FIN:      state_d = ST_OUT;
      ST_OUT: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LATCH;
      end
      ST_DISPATCH: cmd_o.op = OP_DISPATCH;
      ST_TCHG:     cmd_o.op = OP_TCHG;
      ST_SLP_INIT: cmd_o.op = OP_SLP_INIT;
      ST_SLP_A:    cmd_o.op = OP_SLP_A;
      ST_SLP_B:    cmd_o.op = OP_SLP_B;
      ST_TEXP:     cmd_o.op = OP_TEXP;
      ST_CSCAN:    cmd_o.op = OP_CSCAN;
      ST_SMUL:     cmd_o.op = OP_SMUL;
      ST_QRD:      cmd_o.op = OP_QRD;
      ST_FIN:      cmd_o.op = OP_FIN;
      ST_OUT:      cmd_o.op = OP_OUT;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

endmodule

>>> design/rrs_dp.sv
// ----------------------------------------------------------------------------
// rrs_dp: scheduler datapath
// Process table, ready ring, sleep list, tick counters, config registers
// and the result register.
// ----------------------------------------------------------------------------
module rrs_dp
  import rrs_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ctl_cmd_t cmd_i,
  output dp_stat_t stat_o,
  input  rrs_in_t  in_data_i,
  input  logic     cfg_valid_i,
  input  rrs_cfg_t cfg_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rrs_out_t out_data_o
);

  localparam int SW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  // control state
  logic [SW-1:0]        head_q, head_d;
  logic [CW-1:0]        rcnt_q, rcnt_d;
  logic [CW-1:0]        scnt_q, scnt_d;
  logic [7:0]           slice_q, slice_d;
  logic [31:0]          total_q, total_d;
  logic [MAX_TASKS-1:0] used_q, used_d;
  logic [7:0]           cfg_slice_q;
  logic [9:0]           cfg_tps_q;
  logic                 expire_q, expire_d;
  logic                 outv_q, outv_d;

  // per-command working registers
  logic [2:0]    cmd_q, cmd_d;
  logic          user_q, user_d;
  logic [15:0]   secs_q, secs_d;
  logic          was_valid_q, was_valid_d;
  logic [SW-1:0] was_task_q, was_task_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] kept_q, kept_d;
  logic [SW-1:0] s_q, s_d;
  logic [25:0]   prod_q, prod_d;
  status_e       status_q, status_d;
  logic [SW-1:0] created_q, created_d;
  logic [31:0]   sys_out_q, sys_out_d;
  logic [31:0]   usr_out_q, usr_out_d;
  rrs_out_t      out_q, out_d;

  // memories
  logic [SW-1:0] ring_mem [MAX_TASKS];
  logic [SW-1:0] sord_mem [MAX_TASKS];
  logic [31:0]   sleft_mem [MAX_TASKS];
  logic [31:0]   sys_mem [MAX_TASKS];
  logic [31:0]   usr_mem [MAX_TASKS];

  logic          ring_we, sord_we, sleft_we, sys_we, usr_we;
  logic [SW-1:0] ring_wa, ring_wd, ring_ra, ring_rd_q;
  logic [SW-1:0] sord_wa, sord_wd, sord_ra, sord_rd_q;
  logic [SW-1:0] sleft_wa, sleft_ra;
  logic [31:0]   sleft_wd, sleft_rd_q;
  logic [SW-1:0] cnt_wa, cnt_ra;
  logic [31:0]   sys_wd, usr_wd, sys_rd_q, usr_rd_q;

  // ring arithmetic
  logic [CW:0]   tail_sum;
  logic [SW-1:0] tail;
  logic [SW-1:0] head_inc;
  logic          out_free;
  logic          now_valid;
  logic [SW-1:0] now_task;

  assign tail_sum = (CW+1)'(head_q) + (CW+1)'(rcnt_q);
  assign tail     = (tail_sum >= (CW+1)'(MAX_TASKS)) ?
                    SW'(tail_sum - (CW+1)'(MAX_TASKS)) : SW'(tail_sum);
  assign head_inc = (head_q == SW'(MAX_TASKS - 1)) ? '0 : head_q + SW'(1);
  assign out_free = !outv_q || out_ready_i;
  assign now_valid = (rcnt_q != '0);
  assign now_task  = now_valid ? ring_rd_q : '0;

  // status to the sequencer
  always_comb begin
    stat_o.cmd         = cmd_q;
    stat_o.rcount_zero = (rcnt_q == '0);
    stat_o.scount_zero = (scnt_q == '0);
    stat_o.used_cur    = used_q[idx_q[SW-1:0]];
    stat_o.scan_last   = (idx_q == CW'(MAX_TASKS - 1));
    stat_o.slp_last    = ((idx_q + CW'(1)) == scnt_q);
    stat_o.out_free    = out_free;
  end

  // operation decode
  always_comb begin
    head_d = head_q; rcnt_d = rcnt_q; scnt_d = scnt_q; slice_d = slice_q;
    total_d = total_q; used_d = used_q; expire_d = expire_q;
    cmd_d = cmd_q; user_d = user_q; secs_d = secs_q;
    was_valid_d = was_valid_q; was_task_d = was_task_q;
    idx_d = idx_q; kept_d = kept_q; s_d = s_q; prod_d = prod_q;
    status_d = status_q; created_d = created_q;
    sys_out_d = sys_out_q; usr_out_d = usr_out_q;
    out_d = out_q;
    outv_d = outv_q && !out_ready_i;

    ring_we = 1'b0; ring_wa = tail; ring_wd = was_task_q; ring_ra = head_q;
    sord_we = 1'b0; sord_wa = kept_q[SW-1:0]; sord_wd = s_q; sord_ra = '0;
    sleft_we = 1'b0; sleft_wa = s_q; sleft_wd = '0; sleft_ra = s_q;
    sys_we = 1'b0; usr_we = 1'b0; cnt_wa = was_task_q; cnt_ra = was_task_q;
    sys_wd = '0; usr_wd = '0;

    unique case (cmd_i.op)
      OP_LATCH: begin
        cmd_d     = in_data_i.cmd;
        user_d    = in_data_i.from_user;
        secs_d    = in_data_i.sleep_seconds;
        status_d  = STS_OK;
        created_d = '0;
        sys_out_d = '0;
        usr_out_d = '0;
        expire_d  = 1'b0;
      end
      OP_DISPATCH: begin
        was_valid_d = now_valid;
        was_task_d  = now_task;
        idx_d       = '0;
        cnt_ra      = ring_rd_q;
        prod_d      = secs_q * cfg_tps_q;
        if (cmd_q == CMD_TICK) begin
          total_d = total_q + 32'd1;
        end else if (cmd_q == CMD_SLEEP || cmd_q == CMD_TERM || cmd_q == CMD_QUERY) begin
          if (!now_valid) begin
            status_d = STS_NORUN;
          end else if (cmd_q != CMD_QUERY) begin
            // pop the running task
            head_d = head_inc;
            rcnt_d = rcnt_q - CW'(1);
            if (rcnt_q > CW'(1)) slice_d = cfg_slice_q;
            if (cmd_q == CMD_TERM) used_d[ring_rd_q] = 1'b0;
          end
        end
      end
      OP_TCHG: begin
        if (user_q) begin
          usr_we = 1'b1;
          usr_wd = usr_rd_q + 32'd1;
        end else begin
          sys_we = 1'b1;
          sys_wd = sys_rd_q + 32'd1;
        end
        if (slice_q <= 8'd1) begin
          slice_d  = '0;
          expire_d = 1'b1;
        end else begin
          slice_d = slice_q - 8'd1;
        end
      end
      OP_SLP_INIT: begin
        idx_d   = '0;
        kept_d  = '0;
        sord_ra = '0;
      end
      OP_SLP_A: begin
        s_d      = sord_rd_q;
        sleft_ra = sord_rd_q;
      end
      OP_SLP_B: begin
        if (sleft_rd_q <= 32'd1) begin
          // due: append to the ready ring
          if (rcnt_q < CW'(MAX_TASKS)) begin
            ring_we = 1'b1;
            ring_wd = s_q;
            rcnt_d  = rcnt_q + CW'(1);
            if (rcnt_q == '0) slice_d = cfg_slice_q;
          end
        end else begin
          sleft_we = 1'b1;
          sleft_wd = sleft_rd_q - 32'd1;
          sord_we  = 1'b1;
          kept_d   = kept_q + CW'(1);
        end
        idx_d   = idx_q + CW'(1);
        sord_ra = SW'(idx_q + CW'(1));
        if ((idx_q + CW'(1)) == scnt_q) scnt_d = kept_d;
      end
      OP_TEXP: begin
        if (expire_q) begin
          ring_we = 1'b1;
          head_d  = head_inc;
          slice_d = cfg_slice_q;
        end
      end
      OP_CSCAN: begin
        if (!used_q[idx_q[SW-1:0]]) begin
          used_d[idx_q[SW-1:0]] = 1'b1;
          sys_we    = 1'b1;
          usr_we    = 1'b1;
          cnt_wa    = idx_q[SW-1:0];
          created_d = idx_q[SW-1:0];
          if (rcnt_q < CW'(MAX_TASKS)) begin
            ring_we = 1'b1;
            ring_wd = idx_q[SW-1:0];
            rcnt_d  = rcnt_q + CW'(1);
            if (rcnt_q == '0) slice_d = cfg_slice_q;
          end
        end else if (idx_q == CW'(MAX_TASKS - 1)) begin
          status_d = STS_NOSLOT;
        end
        idx_d = idx_q + CW'(1);
      end
      OP_SMUL: begin
        sleft_we = 1'b1;
        sleft_wa = was_task_q;
        sleft_wd = 32'(prod_q);
        if (scnt_q < CW'(MAX_TASKS)) begin
          sord_we = 1'b1;
          sord_wa = scnt_q[SW-1:0];
          sord_wd = was_task_q;
          scnt_d  = scnt_q + CW'(1);
        end
      end
      OP_QRD: begin
        sys_out_d = sys_rd_q;
        usr_out_d = usr_rd_q;
      end
      OP_FIN: begin
        ring_ra = head_q;
      end
      OP_OUT: begin
        if (out_free) begin
          out_d.status        = status_q;
          out_d.running_valid = now_valid;
          out_d.running_task  = 4'(now_task);
          out_d.created_task  = 4'(created_q);
          out_d.switched      = (now_valid != was_valid_q) || (now_task != was_task_q);
          out_d.system_ticks  = sys_out_q;
          out_d.user_ticks    = usr_out_q;
          out_d.total_ticks   = total_q;
          outv_d              = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      rcnt_q      <= '0;
      scnt_q      <= '0;
      slice_q     <= '0;
      total_q     <= '0;
      used_q      <= '0;
      expire_q    <= 1'b0;
      outv_q      <= 1'b0;
      cfg_slice_q <= SLICE_RST;
      cfg_tps_q   <= TPS_RST;
    end else begin
      head_q   <= head_d;
      rcnt_q   <= rcnt_d;
      scnt_q   <= scnt_d;
      slice_q  <= slice_d;
      total_q  <= total_d;
      used_q   <= used_d;
      expire_q <= expire_d;
      outv_q   <= outv_d;
      if (cfg_valid_i) begin
        case (cfg_data_i.index)
          CFG_SLICE: cfg_slice_q <= cfg_data_i.value[7:0];
          CFG_TPS:   cfg_tps_q   <= cfg_data_i.value;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    user_q      <= user_d;
    secs_q      <= secs_d;
    was_valid_q <= was_valid_d;
    was_task_q  <= was_task_d;
    idx_q       <= idx_d;
    kept_q      <= kept_d;
    s_q         <= s_d;
    prod_q      <= prod_d;
    status_q    <= status_d;
    created_q   <= created_d;
    sys_out_q   <= sys_out_d;
    usr_out_q   <= usr_out_d;
    out_q       <= out_d;
  end

  // ready ring
  always_ff @(posedge clk_i) begin
    if (ring_we) ring_mem[ring_wa] <= ring_wd;
    ring_rd_q <= ring_mem[ring_ra];
  end

  // sleep order list
  always_ff @(posedge clk_i) begin
    if (sord_we) sord_mem[sord_wa] <= sord_wd;
    sord_rd_q <= sord_mem[sord_ra];
  end

  // sleep ticks left
  always_ff @(posedge clk_i) begin
    if (sleft_we) sleft_mem[sleft_wa] <= sleft_wd;
    sleft_rd_q <= sleft_mem[sleft_ra];
  end

  // per-task tick counters
  always_ff @(posedge clk_i) begin
    if (sys_we) sys_mem[cnt_wa] <= sys_wd;
    if (usr_we) usr_mem[cnt_wa] <= usr_wd;
    sys_rd_q <= sys_mem[cnt_ra];
    usr_rd_q <= usr_mem[cnt_ra];
  end

  assign out_valid_o = outv_q;
  assign out_data_o  = out_q;

endmodule

>>> design/round_robin_scheduler_with_sleep.sv
// ----------------------------------------------------------------------------
// round_robin_scheduler_with_sleep: round-robin task scheduler
// Fixed process table with ready ring, time slices and a sleep list.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | beat
//  in_i    | in  | cmd, from_user, sleep_seconds            | one command
//  out_o   | out | status, running, created, switched, cnts | one result
//  cfg_i   | in  | index, value                             | one reg write
//
//  Tick: charges the running task if any, then visits each sleeper.
//  Create: table scan through the occupied slots before the free one.
//  Sleep writes the sleep list, query reads the counters, if a task runs.
//  Reset clears the table and queues at once; no clearing pass.
//  A finished result waits in the output register while the next command
//  is accepted; a command only stalls at its last step if that is still full.
// ----------------------------------------------------------------------------
module round_robin_scheduler_with_sleep
  import rrs_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  rrs_chan_if.sink   in_i,
  rrs_chan_if.source out_o,
  rrs_chan_if.sink   cfg_i
);

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  assign cfg_i.ready = 1'b1;

  rrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (dp_stat),
    .cmd_o      (ctl_cmd)
  );

  rrs_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctl_cmd),
    .stat_o      (dp_stat),
    .in_data_i   (in_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule

>>> design/rrs_checker.sv
// ----------------------------------------------------------------------------
// rrs_checker: port-level checks of the scheduler
// Watches the command and result channels from outside.
// ----------------------------------------------------------------------------
module rrs_checker
  import rrs_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input rrs_out_t out_data_i
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result beat changed while stalled");

  // idle scheduler reports slot zero
  a_idle_task: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.running_valid |-> out_data_i.running_task == 4'd0)
    else $error("running task given with no running task");

  // no-running-task answer carries nothing
  a_norun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status == STS_NORUN |->
      !out_data_i.running_valid && out_data_i.system_ticks == 32'd0 &&
      out_data_i.user_ticks == 32'd0 && !out_data_i.switched)
    else $error("bad result for no running task");

  // commands are never accepted back to back
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("command accepted on back-to-back cycles");

endmodule

bind round_robin_scheduler_with_sleep rrs_checker u_rrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
